// ===== hw/rtl/ifdd_pkg.sv =====
// Shared constants, result codes and types for the information frame deframer.
`timescale 1ns / 1ps

package ifdd_pkg;

  // Line bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;

  // Low seven bits of the supervision reply control byte
  localparam logic [6:0] ACK_LOW = 7'h05;
  localparam logic [6:0] REJ_LOW = 7'h01;

  // Reset value of the address register
  localparam logic [7:0] ADDR_RESET = 8'h03;

  // Default saturation limit of the payload byte count
  localparam int MAX_PAYLOAD_BYTES_DEF = 1024;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_REPEAT  = 2'd3;

  // Fixed-width part of one result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] reply_control;
  } frm_res_t;

endpackage

// ===== hw/rtl/ifdd_frame.sv =====
// Frame hunt, header check, de-stuffing and frame-end check for one byte per cycle in which step is high.
`timescale 1ns / 1ps

module ifdd_frame import ifdd_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int LenW = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,        // process rx_byte this cycle
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      address_byte,
  output logic            res_valid,
  output frm_res_t        res,
  output logic [LenW-1:0] res_len
);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_FLAG  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_CTRL  = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;

  localparam logic [LenW-1:0] LenMax = LenW'(MAX_PAYLOAD_BYTES);

  logic [2:0]      state_r, state_nxt;
  logic            esc_r, esc_nxt;
  logic [7:0]      check_r, check_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            held_valid_r, held_valid_nxt;
  logic [LenW-1:0] count_r, count_nxt;
  logic            seq_r, seq_nxt;

  logic [7:0] ctrl_exp;
  logic [7:0] ctrl_other;
  logic       take;       // byte goes into the payload hold stage

  assign ctrl_exp   = {seq_r, 7'd0};
  assign ctrl_other = {~seq_r, 7'd0};

  // Next state and result for the byte at hand
  always_comb begin
    state_nxt      = state_r;
    esc_nxt        = esc_r;
    check_nxt      = check_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    count_nxt      = count_r;
    seq_nxt        = seq_r;
    res_valid      = 1'b0;
    res            = '0;
    res_len        = '0;
    take           = 1'b0;

    unique case (state_r)
      ST_START: begin
        if (rx_byte == FLAG_BYTE) state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        if (rx_byte == FLAG_BYTE)         state_nxt = ST_FLAG;
        else if (rx_byte == address_byte) state_nxt = ST_ADDR;
        else                              state_nxt = ST_START;
      end
      ST_ADDR: begin
        if (rx_byte == FLAG_BYTE) begin
          state_nxt = ST_FLAG;
        end else if (rx_byte == ctrl_exp) begin
          state_nxt = ST_CTRL;
        end else if (rx_byte == ctrl_other) begin
          // repeated frame: acknowledge again right away
          state_nxt         = ST_START;
          res_valid         = 1'b1;
          res.kind          = KIND_REPEAT;
          res.reply_control = {seq_r, ACK_LOW};
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_CTRL: begin
        if (rx_byte == FLAG_BYTE) begin
          state_nxt = ST_FLAG;
        end else if (rx_byte == (address_byte ^ ctrl_exp)) begin
          state_nxt      = ST_DATA;
          esc_nxt        = 1'b0;
          check_nxt      = '0;
          held_nxt       = '0;
          held_valid_nxt = 1'b0;
          count_nxt      = '0;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_DATA: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          take    = 1'b1;
        end else if (rx_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else if (rx_byte == FLAG_BYTE) begin
          // closing flag: held byte must equal XOR of the payload
          state_nxt = ST_START;
          res_valid = 1'b1;
          res_len   = count_r;
          if (held_valid_r && (check_r == held_r)) begin
            seq_nxt           = ~seq_r;
            res.kind          = KIND_GOOD;
            res.reply_control = {~seq_r, ACK_LOW};
          end else begin
            res.kind          = KIND_ERROR;
            res.reply_control = {~seq_r, REJ_LOW};
          end
          esc_nxt        = 1'b0;
          check_nxt      = '0;
          held_nxt       = '0;
          held_valid_nxt = 1'b0;
          count_nxt      = '0;
        end else begin
          take = 1'b1;
        end
      end
      default: state_nxt = ST_START;
    endcase

    // Payload byte: release the held one, hold the new one
    if (take) begin
      if (held_valid_r) begin
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = held_r;
        check_nxt     = check_r ^ held_r;
        if (count_r < LenMax) count_nxt = count_r + 1'b1;
      end
      held_nxt       = rx_byte;
      held_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_START;
      esc_r        <= 1'b0;
      check_r      <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      count_r      <= '0;
      seq_r        <= 1'b0;
    end else if (step) begin
      state_r      <= state_nxt;
      esc_r        <= esc_nxt;
      check_r      <= check_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      count_r      <= count_nxt;
      seq_r        <= seq_nxt;
    end
  end

endmodule

// ===== hw/rtl/info_frame_destuffing_deframer.sv =====
// Top level of the information frame deframer: input register, frame logic, output register.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one received line byte per transfer (in_rx_byte), valid/ready.
//   out_* : zero or one result per line byte: a de-stuffed payload byte
//           (released one byte late), or a frame-end report (good, check
//           error/empty, repeated frame) with the reply control byte and the
//           saturating payload length. valid/ready.
//   cfg_* : write of the address register; write only while the block idles.
// Path: a byte taken into the input register is processed by the frame logic
// into the output register, and its result is presented on out_* from there.
// Throughput: one byte per cycle while out_ready holds, as the frame state is
// updated on each step between the input register and the output register.
// Stall: while a result waits on out_ready, one more byte is taken into the
// input register; further input waits until the result is taken.
// Reset: hunts for a flag, expected sequence bit 0, address register 0x03.
module info_frame_destuffing_deframer import ifdd_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int LenW = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  // line bytes
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  // results
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_reply_control,
  output logic [LenW-1:0] out_payload_length,
  // address register write
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_address_byte
);

  logic            in_valid_r;
  logic [7:0]      byte_r;
  logic            out_valid_r;
  frm_res_t        res_r;
  logic [LenW-1:0] len_r;
  logic [7:0]      addr_r;

  logic            step;
  logic            res_valid;
  frm_res_t        res;
  logic [LenW-1:0] res_len;

  // Byte in the input register moves on when the output register is free
  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  // Address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (cfg_valid) begin
      addr_r <= cfg_address_byte;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_rx_byte;
  end

  ifdd_frame #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (byte_r),
    .address_byte(addr_r),
    .res_valid   (res_valid),
    .res         (res),
    .res_len     (res_len)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
      len_r <= res_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_data_byte      = res_r.data_byte;
  assign out_reply_control  = res_r.reply_control;
  assign out_payload_length = len_r;

  // A byte waiting in the input register is neither lost nor changed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(byte_r))
    else $error("input register dropped or changed a waiting byte");

  // Only frame-end reports carry a length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PAYLOAD || out_kind == KIND_REPEAT)
      |-> out_payload_length == '0)
    else $error("length on a result that is not a frame end");

  // Good frames and repeats acknowledge, errors reject
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_GOOD || out_kind == KIND_REPEAT)
      |-> out_reply_control[6:0] == ACK_LOW)
    else $error("acknowledge reply has wrong control code");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_reply_control[6:0] == REJ_LOW)
    else $error("reject reply has wrong control code");

  // Data byte is zero except on payload results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data_byte == 8'd0)
    else $error("data byte set on a frame-end result");

endmodule
